// File: rtl/core/vks_pkg.sv
// ----------------------------------------------------------------------------
// vks_pkg
// Shared types and constants of the velocity key scanner.
// ----------------------------------------------------------------------------
package vks_pkg;

	localparam int unsigned NumKeys = 88;

	localparam int KeyW     = 7;
	localparam int KeyIdxW  = (NumKeys > 1) ? $clog2(NumKeys) : 1;
	localparam int StampW   = 32;
	localparam int HoldW    = 20;
	localparam int NoteW    = 7;
	localparam int VelW     = 7;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 20;

	localparam logic [KeyW:0]   NumKeysCmp   = (KeyW + 1)'(NumKeys);
	localparam logic [HoldW-1:0] HoldReset   = HoldW'(10000);
	localparam logic [NoteW-1:0] OffsetReset = NoteW'(21);

	// velocity ramp
	localparam int unsigned VelFastUs = 3500;
	localparam int unsigned VelSlowUs = 200000;
	localparam int unsigned VelTop    = 127;
	localparam int unsigned VelBottom = 1;
	localparam int unsigned VelSpan   = VelSlowUs - VelFastUs;
	localparam int unsigned VelScale  = VelTop - VelBottom;
	localparam int VelDiffW   = $clog2(VelSpan + 1);
	localparam int VelProdInW = $clog2(VelSpan * VelScale + 1);
	// exact floor division by reciprocal: x * err < 2^shift
	localparam int VelShift   = VelProdInW + VelDiffW;
	localparam longint unsigned VelRecipL =
		((64'd1 << VelShift) + 64'(VelSpan) - 64'd1) / 64'(VelSpan);
	localparam int VelRecipW  = $clog2(VelRecipL + 1);
	localparam logic [VelRecipW-1:0] VelRecip = VelRecipW'(VelRecipL);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_FALL = 3'd1,
		PH_DOWN = 3'd2,
		PH_RISE = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RELEASE_HOLD = 1'b0,
		CFG_NOTE_OFFSET  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		phase_t              phase;
		logic [StampW-1:0]   stamp;
	} key_entry_t;

	typedef struct packed {
		logic                en;
		logic [KeyIdxW-1:0]  idx;
		key_entry_t          entry;
	} store_wr_t;

	typedef struct packed {
		logic                valid;
		logic                on;
		logic [NoteW-1:0]    note;
		logic [StampW-1:0]   t;
	} vel_req_t;

endpackage

// File: rtl/core/vks_key_if.sv
// ----------------------------------------------------------------------------
// vks_key_if
// Key sample channel: one contact sample of one key per transaction.
// ----------------------------------------------------------------------------
interface vks_key_if;
	logic                      valid;
	logic                      ready;
	logic [vks_pkg::KeyW-1:0]  key_index;
	logic                      first_contact;
	logic                      second_contact;
	logic [vks_pkg::StampW-1:0] now_us;

	modport source (
		output valid,
		output key_index,
		output first_contact,
		output second_contact,
		output now_us,
		input  ready
	);

	modport sink (
		input  valid,
		input  key_index,
		input  first_contact,
		input  second_contact,
		input  now_us,
		output ready
	);
endinterface

// File: rtl/core/vks_note_if.sv
// ----------------------------------------------------------------------------
// vks_note_if
// Note event channel: note number and velocity per transaction.
// ----------------------------------------------------------------------------
interface vks_note_if;
	logic                      valid;
	logic                      ready;
	logic [vks_pkg::NoteW-1:0] note_number;
	logic [vks_pkg::VelW-1:0]  velocity;

	modport source (
		output valid,
		output note_number,
		output velocity,
		input  ready
	);

	modport sink (
		input  valid,
		input  note_number,
		input  velocity,
		output ready
	);
endinterface

// File: rtl/core/vks_key_store.sv
// ----------------------------------------------------------------------------
// vks_key_store
// Per-key phase and timestamp memory, one read and one write port, with
// valid bits for the phase reset and forwarding of the latest write.
// ----------------------------------------------------------------------------
module vks_key_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [vks_pkg::KeyIdxW-1:0]   rd_idx,
	input  vks_pkg::store_wr_t            wr,
	output vks_pkg::key_entry_t           rd_entry
);

	vks_pkg::key_entry_t                mem_q [vks_pkg::NumKeys];
	logic [vks_pkg::NumKeys-1:0]        vld_q;
	vks_pkg::key_entry_t                rd_data_q;
	logic                               rd_vld_q;
	logic [vks_pkg::KeyIdxW-1:0]        rd_idx_q;
	logic                               fwd_v_q;
	logic [vks_pkg::KeyIdxW-1:0]        fwd_idx_q;
	vks_pkg::key_entry_t                fwd_entry_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.idx] <= wr.entry;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
			rd_vld_q  <= vld_q[rd_idx];
			rd_idx_q  <= rd_idx;
		end
		if (wr.en) begin
			fwd_idx_q   <= wr.idx;
			fwd_entry_q <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else if (wr.en) begin
			vld_q[wr.idx] <= 1'b1;
			fwd_v_q       <= 1'b1;
		end
	end

	// latest write wins over the registered read of the same key
	always_comb begin
		if (fwd_v_q && (fwd_idx_q == rd_idx_q)) begin
			rd_entry = fwd_entry_q;
		end else if (rd_vld_q) begin
			rd_entry = rd_data_q;
		end else begin
			rd_entry.phase = vks_pkg::PH_IDLE;
			rd_entry.stamp = '0;
		end
	end

endmodule

// File: rtl/core/vks_velocity.sv
// ----------------------------------------------------------------------------
// vks_velocity
// Velocity pipeline: range classification, scaling, reciprocal multiply
// and the output register of the note channel.
// ----------------------------------------------------------------------------
module vks_velocity (
	input  logic               clk,
	input  logic               arst_n,
	input  vks_pkg::vel_req_t  req,
	output logic               req_ready,
	vks_note_if.source         note
);

	typedef enum logic [1:0] {
		VS_ZERO,
		VS_TOP,
		VS_RAMP
	} vsel_t;

	localparam int ProdW = vks_pkg::VelProdInW + vks_pkg::VelRecipW;

	logic                                v_s2;
	logic                                on_s2;
	logic [vks_pkg::NoteW-1:0]           note_s2;
	logic [vks_pkg::StampW-1:0]          t_s2;
	logic                                v_s3;
	logic [vks_pkg::NoteW-1:0]           note_s3;
	vsel_t                               sel_s3;
	logic [vks_pkg::VelProdInW-1:0]      x_s3;
	logic                                v_s4;
	logic [vks_pkg::NoteW-1:0]           note_s4;
	vsel_t                               sel_s4;
	logic [vks_pkg::VelW-1:0]            drop_s4;
	logic                                out_v_q;
	logic [vks_pkg::NoteW-1:0]           note_q;
	logic [vks_pkg::VelW-1:0]            vel_q;

	logic                                rdy_s3;
	logic                                rdy_s4;
	logic                                rdy_out;
	logic                                slow;
	logic                                fast;
	logic [vks_pkg::VelDiffW-1:0]        diff;
	logic [vks_pkg::VelProdInW-1:0]      x;
	vsel_t                               sel;
	logic [ProdW-1:0]                    prod;
	logic [vks_pkg::VelW-1:0]            vel;

	assign rdy_out   = !out_v_q || note.ready;
	assign rdy_s4    = !v_s4 || rdy_out;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign req_ready = !v_s2 || rdy_s3;

	// classify elapsed time and scale the ramp offset
	always_comb begin
		slow = t_s2 > vks_pkg::StampW'(vks_pkg::VelSlowUs);
		fast = t_s2 <= vks_pkg::StampW'(vks_pkg::VelFastUs);
		diff = vks_pkg::VelDiffW'(t_s2 - vks_pkg::StampW'(vks_pkg::VelFastUs));
		x    = vks_pkg::VelProdInW'(diff) * vks_pkg::VelProdInW'(vks_pkg::VelScale);
		if (!on_s2 || slow) begin
			sel = VS_ZERO;
		end else if (fast) begin
			sel = VS_TOP;
		end else begin
			sel = VS_RAMP;
		end
	end

	assign prod = ProdW'(x_s3) * ProdW'(vks_pkg::VelRecip);

	always_comb begin
		unique case (sel_s4)
			VS_ZERO: vel = '0;
			VS_TOP:  vel = vks_pkg::VelW'(vks_pkg::VelTop);
			VS_RAMP: vel = vks_pkg::VelW'(vks_pkg::VelTop) - drop_s4;
			default: vel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (req_ready) begin
				v_s2 <= req.valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_out) begin
				out_v_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready) begin
			on_s2   <= req.on;
			note_s2 <= req.note;
			t_s2    <= req.t;
		end
		if (rdy_s3) begin
			note_s3 <= note_s2;
			sel_s3  <= sel;
			x_s3    <= x;
		end
		if (rdy_s4) begin
			note_s4 <= note_s3;
			sel_s4  <= sel_s3;
			drop_s4 <= prod[vks_pkg::VelShift +: vks_pkg::VelW];
		end
		if (rdy_out) begin
			note_q <= note_s4;
			vel_q  <= vel;
		end
	end

	assign note.valid       = out_v_q;
	assign note.note_number = note_q;
	assign note.velocity    = vel_q;

endmodule

// File: rtl/core/velocity_key_scan_fsm_top.sv
// ----------------------------------------------------------------------------
// velocity_key_scan_fsm_top
// Dual-contact velocity keyboard scanner: per-key phase machine over a
// phase/timestamp memory, emitting note-on and note-off events.
// ----------------------------------------------------------------------------
// One key sample is taken every clock cycle unless a stalled velocity
// pipeline holds the sample stage. The phase and timestamp of the sampled key
// are read from a single-port-read, single-port-write memory at the accepting
// edge, updated and written back when the velocity pipeline takes the sample,
// with the last write forwarded so that consecutive samples of the same key
// see each other. A note event passes through the sample, velocity request,
// classification and reciprocal multiply registers to the output register,
// where it becomes valid. A stalled output holds the pipeline only once its
// stages are full. The phase memory starts idle after reset through per-key
// valid bits, so samples are accepted right away.
// ----------------------------------------------------------------------------
module velocity_key_scan_fsm_top (
	input  logic                           clk,
	input  logic                           arst_n,
	vks_key_if.sink                        key,
	vks_note_if.source                     note,
	input  logic                           cfg_we,
	input  logic [vks_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [vks_pkg::CfgDataW-1:0]   cfg_data
);

	logic [vks_pkg::HoldW-1:0]    hold_q;
	logic [vks_pkg::NoteW-1:0]    offset_q;

	logic                         v_s1;
	logic                         hit_s1;
	logic [vks_pkg::KeyW-1:0]     key_s1;
	logic                         br_s1;
	logic                         mk_s1;
	logic [vks_pkg::StampW-1:0]   now_s1;

	logic                         accept;
	logic                         in_range;
	logic                         vel_ready;
	vks_pkg::key_entry_t          cur;
	vks_pkg::key_entry_t          nxt;
	vks_pkg::store_wr_t           wr;
	vks_pkg::vel_req_t            req;
	logic [vks_pkg::StampW-1:0]   elapsed;
	logic                         emit;
	logic                         note_on;

	assign in_range  = {1'b0, key.key_index} < vks_pkg::NumKeysCmp;
	assign key.ready = !v_s1 || vel_ready;
	assign accept    = key.valid && key.ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= vks_pkg::HoldReset;
			offset_q <= vks_pkg::OffsetReset;
		end else if (cfg_we) begin
			unique case (vks_pkg::cfg_reg_t'(cfg_index))
				vks_pkg::CFG_RELEASE_HOLD: hold_q   <= cfg_data[vks_pkg::HoldW-1:0];
				vks_pkg::CFG_NOTE_OFFSET:  offset_q <= cfg_data[vks_pkg::NoteW-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (key.ready) begin
			v_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1 <= in_range;
			key_s1 <= key.key_index;
			br_s1  <= key.first_contact;
			mk_s1  <= key.second_contact;
			now_s1 <= key.now_us;
		end
	end

	vks_key_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && in_range),
		.rd_idx   (key.key_index[vks_pkg::KeyIdxW-1:0]),
		.wr       (wr),
		.rd_entry (cur)
	);

	assign elapsed = now_s1 - cur.stamp;

	// per-key phase machine, checks chained in one step
	always_comb begin
		nxt     = cur;
		emit    = 1'b0;
		note_on = 1'b0;
		unique case (cur.phase)
			vks_pkg::PH_IDLE: begin
				if (br_s1 && mk_s1) begin
					nxt.phase = vks_pkg::PH_FALL;
					nxt.stamp = now_s1;
				end
			end
			vks_pkg::PH_FALL: begin
				if (!br_s1) begin
					nxt.phase = vks_pkg::PH_IDLE;
				end else if (!mk_s1) begin
					nxt.phase = vks_pkg::PH_DOWN;
					emit      = 1'b1;
					note_on   = 1'b1;
				end
			end
			vks_pkg::PH_DOWN: begin
				if (br_s1 && mk_s1) begin
					nxt.phase = vks_pkg::PH_RISE;
					nxt.stamp = now_s1;
				end
			end
			vks_pkg::PH_RISE: begin
				if (!mk_s1) begin
					nxt.phase = vks_pkg::PH_DOWN;
				end else if (elapsed > vks_pkg::StampW'(hold_q)) begin
					nxt.phase = br_s1 ? vks_pkg::PH_DONE : vks_pkg::PH_IDLE;
					emit      = 1'b1;
				end
			end
			vks_pkg::PH_DONE: begin
				if (!br_s1) begin
					nxt.phase = vks_pkg::PH_IDLE;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		wr.en     = v_s1 && hit_s1 && vel_ready;
		wr.idx    = key_s1[vks_pkg::KeyIdxW-1:0];
		wr.entry  = nxt;
		req.valid = v_s1 && hit_s1 && emit;
		req.on    = note_on;
		req.note  = vks_pkg::NoteW'(key_s1 + offset_q);
		req.t     = elapsed;
	end

	vks_velocity u_velocity (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_ready (vel_ready),
		.note      (note)
	);

endmodule
